[rtl/core/ctm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types, codes and helpers for the cron table minute matcher.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_OPEN  = 3'd1;
  localparam logic [2:0] CMD_CLOSE = 3'd2;
  localparam logic [2:0] CMD_OFF   = 3'd3;
  localparam logic [2:0] CMD_TEST  = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] minute;
    logic       minute_any;
    logic [4:0] hour;
    logic       hour_any;
    logic [4:0] mday;
    logic       mday_any;
    logic [3:0] month;
    logic       month_any;
    logic [2:0] wday;
    logic       wday_any;
    logic [2:0] command;
  } ctm_in_t;

  typedef struct packed {
    logic       fired;
    logic [2:0] fired_command;
    logic [3:0] job_index;
    logic [4:0] job_count;
    logic       table_full;
    logic       last;
  } ctm_out_t;

  // one stored job, 31 bits
  typedef struct packed {
    logic [5:0] minute;
    logic       minute_any;
    logic [4:0] hour;
    logic       hour_any;
    logic [4:0] mday;
    logic       mday_any;
    logic [3:0] month;
    logic       month_any;
    logic [2:0] wday;
    logic       wday_any;
    logic [2:0] command;
  } job_entry_t;

  // current calendar fields of a tick
  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [2:0] wday;
  } tick_t;

  // 3-bit weekday mod 7: only 7 wraps to sunday
  function automatic logic [2:0] wday_mod7(input logic [2:0] wd);
    logic [2:0] res;
    res = (wd == 3'd7) ? 3'd0 : wd;
    return res;
  endfunction

endpackage

[rtl/core/ctm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctm_if
// Valid/ready channels for the job items and the match results.
// ----------------------------------------------------------------------------
interface ctm_in_if import ctm_pkg::*; ();
  logic    valid;
  logic    ready;
  ctm_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ctm_out_if import ctm_pkg::*; ();
  logic     valid;
  logic     ready;
  ctm_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/cron_table_minute_matcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_table_minute_matcher_unit
// Job table with wildcard calendar matching, walked newest to oldest.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one item per transaction: add a job, clear the table,
//   or a minute tick with the current calendar fields. out_chan returns the
//   results; every item gives at least one, and the final one has last = 1.
//   An add answers with the slot it wrote, or table_full when 16 jobs are
//   stored. A tick gives one result per matching job with a known command,
//   newest slot first, or one empty result when nothing fires.
// Timing:
//   in_chan.ready is high only while the block is idle. An add, clear or
//   unused action is accepted, then executed into the output register. For
//   a tick, the table is a memory with one write port and a registered read,
//   and the walk compares one slot per cycle through one compare unit,
//   except while it pauses as described below.
// Stalls and reset:
//   The output register holds a result until out_chan.ready; the walk
//   pauses when a further result is found while the previous one waits.
//   Reset empties the table (count to zero) and drops any pending result.
// ----------------------------------------------------------------------------
module cron_table_minute_matcher_unit
  import ctm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ctm_in_if.sink           in_chan,
  ctm_out_if.source        out_chan
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  ctm_in_t           item_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic              have_pend_r, have_pend_nxt;
  logic [2:0]        pend_cmd_r, pend_cmd_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;

  job_entry_t        mem [MAX_JOBS];
  job_entry_t        rd_data_r;
  job_entry_t        wr_entry;
  logic              wr_en;

  tick_t             tick;
  logic              fire;

  logic              out_valid_r;
  ctm_out_t          out_r;
  logic              can_load;
  logic              ld;
  ctm_out_t          ld_data;

  logic              accept;

  assign accept   = in_chan.valid & in_chan.ready;
  assign can_load = ~out_valid_r | out_chan.ready;

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  always_comb begin
    wr_entry.minute     = item_r.minute;
    wr_entry.minute_any = item_r.minute_any;
    wr_entry.hour       = item_r.hour;
    wr_entry.hour_any   = item_r.hour_any;
    wr_entry.mday       = item_r.mday;
    wr_entry.mday_any   = item_r.mday_any;
    wr_entry.month      = item_r.month;
    wr_entry.month_any  = item_r.month_any;
    wr_entry.wday       = item_r.wday;
    wr_entry.wday_any   = item_r.wday_any;
    wr_entry.command    = item_r.command;

    tick.minute = item_r.minute;
    tick.hour   = item_r.hour;
    tick.mday   = item_r.mday;
    tick.month  = item_r.month;
    tick.wday   = item_r.wday;
  end

  ctm_entry_match u_match (
    .entry (rd_data_r),
    .tick  (tick),
    .fire  (fire)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    have_pend_nxt = have_pend_r;
    pend_cmd_nxt  = pend_cmd_r;
    pend_idx_nxt  = pend_idx_r;
    wr_en         = 1'b0;
    ld            = 1'b0;
    ld_data       = '0;
    ld_data.last  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.action)
          ACT_ADD: begin
            if (can_load) begin
              ld        = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == CNT_W'(MAX_JOBS)) begin
                ld_data.table_full = 1'b1;
                ld_data.job_count  = 5'(count_r);
              end else begin
                wr_en             = 1'b1;
                count_nxt         = count_r + 1'b1;
                ld_data.job_index = 4'(count_r[IDX_W-1:0]);
                ld_data.job_count = 5'(count_nxt);
              end
            end
          end
          ACT_CLEAR: begin
            if (can_load) begin
              ld        = 1'b1;
              count_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
          ACT_TICK: begin
            have_pend_nxt = 1'b0;
            if (count_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              ptr_nxt   = IDX_W'(count_r - 1'b1);
              state_nxt = S_WALK;
            end
          end
          default: begin
            if (can_load) begin
              ld                = 1'b1;
              ld_data.job_count = 5'(count_r);
              state_nxt         = S_IDLE;
            end
          end
        endcase
      end
      S_WALK: begin
        // a second hit must wait until the previous one can be sent
        if (!(fire && have_pend_r && !can_load)) begin
          if (fire) begin
            if (have_pend_r) begin
              ld                    = 1'b1;
              ld_data.fired         = 1'b1;
              ld_data.fired_command = pend_cmd_r;
              ld_data.job_index     = 4'(pend_idx_r);
              ld_data.job_count     = 5'(count_r);
              ld_data.last          = 1'b0;
            end
            have_pend_nxt = 1'b1;
            pend_cmd_nxt  = rd_data_r.command;
            pend_idx_nxt  = ptr_r;
          end
          if (ptr_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (can_load) begin
          ld                = 1'b1;
          ld_data.job_count = 5'(count_r);
          if (have_pend_r) begin
            ld_data.fired         = 1'b1;
            ld_data.fired_command = pend_cmd_r;
            ld_data.job_index     = 4'(pend_idx_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // job table: one write port, registered read following the walk pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      have_pend_r <= have_pend_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pend_cmd_r <= pend_cmd_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (accept) begin
      item_r <= in_chan.payload;
    end
    if (ld) begin
      out_r <= ld_data;
    end
  end

endmodule

[rtl/core/ctm_entry_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctm_entry_match
// Compare unit shared by the table walk: one stored job against a tick.
// ----------------------------------------------------------------------------
module ctm_entry_match
  import ctm_pkg::*;
(
  input  job_entry_t entry,
  input  tick_t      tick,
  output logic       fire
);

  logic min_ok, hr_ok, mday_ok, mon_ok, wday_ok, cmd_ok;

  always_comb begin
    min_ok  = entry.minute_any | (entry.minute == tick.minute);
    hr_ok   = entry.hour_any   | (entry.hour == tick.hour);
    mday_ok = entry.mday_any   | (entry.mday == tick.mday);
    mon_ok  = entry.month_any  | (entry.month == tick.month);
    // tick weekday is compared as given, so a tick weekday of 7 never hits a job that names a weekday
    wday_ok = entry.wday_any   | (wday_mod7(entry.wday) == tick.wday);
    cmd_ok  = (entry.command >= CMD_OPEN) && (entry.command <= CMD_TEST);
    fire    = min_ok & hr_ok & mday_ok & mon_ok & wday_ok & cmd_ok;
  end

endmodule

[bench/cron_table_minute_matcher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_table_minute_matcher_unit_tb
// Sends add, clear and tick transactions into the job table. A local copy of
// the table predicts every match result, and the result stream is checked in
// order. The input side runs in random bursts and the output side stalls.
// ----------------------------------------------------------------------------
module cron_table_minute_matcher_unit_tb;
  import ctm_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [2:0] CMD_BAD     = 3'd7;
  localparam int         RESULT_CAP  = 16;
  localparam int         RAND_ITEMS  = 380;
  localparam int         MAX_REPORTS = 10;
  localparam logic [2:0] CMD_CYCLE [4] = '{CMD_OPEN, CMD_CLOSE, CMD_OFF, CMD_TEST};

  typedef struct {
    ctm_in_t  item;
    bit       typed;
    ctm_out_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ctm_in_if  in_chan();
  ctm_out_if out_chan();

  cron_table_minute_matcher_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  job_entry_t  sched_jobs [MAX_JOBS];
  int unsigned sched_count = 0;
  ctm_out_t    step_results [$];
  ctm_out_t    pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_cnt = 0;
  int unsigned out_cyc = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic ctm_in_t mk_item(logic [1:0] act, logic [5:0] mi, logic mi_any,
                                      logic [4:0] hr, logic hr_any, logic [4:0] md,
                                      logic md_any, logic [3:0] mo, logic mo_any,
                                      logic [2:0] wd, logic wd_any, logic [2:0] cmd);
    ctm_in_t it;
    it = '{act, mi, mi_any, hr, hr_any, md, md_any, mo, mo_any, wd, wd_any, cmd};
    return it;
  endfunction

  function automatic ctm_out_t mk_res(logic fired, logic [2:0] cmd, logic [3:0] idx,
                                     logic [4:0] cnt, logic full, logic last);
    ctm_out_t r;
    r = '{fired, cmd, idx, cnt, full, last};
    return r;
  endfunction

  function automatic string fmt_res(ctm_out_t r);
    return $sformatf("fired=%0b cmd=%0d idx=%0d count=%0d full=%0b last=%0b",
                     r.fired, r.fired_command, r.job_index, r.job_count,
                     r.table_full, r.last);
  endfunction

  // predicts the results of one transaction and updates the local table
  function automatic void step_schedule(ctm_in_t it);
    int         n;
    job_entry_t j;
    bit         hit;
    step_results.delete();
    n = 0;
    case (it.action)
      ACT_ADD: begin
        if (sched_count >= MAX_JOBS) begin
          step_results.push_back(mk_res(1'b0, CMD_NONE, 4'd0, 5'(sched_count), 1'b1, 1'b1));
        end else begin
          sched_jobs[sched_count] = '{it.minute, it.minute_any, it.hour, it.hour_any,
                                      it.mday, it.mday_any, it.month, it.month_any,
                                      it.wday, it.wday_any, it.command};
          sched_count++;
          step_results.push_back(mk_res(1'b0, CMD_NONE, 4'(sched_count - 1),
                                        5'(sched_count), 1'b0, 1'b1));
        end
      end
      ACT_CLEAR: begin
        sched_count = 0;
        step_results.push_back(mk_res(1'b0, CMD_NONE, 4'd0, 5'd0, 1'b0, 1'b1));
      end
      ACT_TICK: begin
        for (int i = int'(sched_count) - 1; i >= 0 && n < RESULT_CAP; i--) begin
          j = sched_jobs[i];
          // job weekday 7 folds onto sunday, the tick weekday is taken as is
          hit = (j.command >= CMD_OPEN && j.command <= CMD_TEST)
             && (j.minute_any || j.minute == it.minute)
             && (j.hour_any   || j.hour   == it.hour)
             && (j.mday_any   || j.mday   == it.mday)
             && (j.month_any  || j.month  == it.month)
             && (j.wday_any   || (j.wday % 3'd7) == it.wday);
          if (hit) begin
            step_results.push_back(mk_res(1'b1, j.command, 4'(i), 5'(sched_count),
                                          1'b0, 1'b0));
            n++;
          end
        end
        if (n == 0) begin
          step_results.push_back(mk_res(1'b0, CMD_NONE, 4'd0, 5'(sched_count), 1'b0, 1'b1));
        end else begin
          step_results[n - 1].last = 1'b1;
        end
      end
      default: begin
        step_results.push_back(mk_res(1'b0, CMD_NONE, 4'd0, 5'(sched_count), 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic ctm_in_t rand_item();
    ctm_in_t     it;
    logic [63:0] raw;
    job_entry_t  j;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    it   = ctm_in_t'(raw[$bits(ctm_in_t)-1:0]);
    // a few transactions keep every field raw, out-of-range values included
    if (pick >= 8) begin
      it.minute = 6'($urandom_range(0, 59));
      it.hour   = 5'($urandom_range(0, 23));
      it.mday   = 5'($urandom_range(1, 31));
      it.month  = 4'($urandom_range(1, 12));
      it.wday   = 3'($urandom_range(0, 7));
      if (pick < 46) begin
        it.action = ACT_ADD;
        if ($urandom_range(0, 5) != 0) it.command = 3'($urandom_range(1, 4));
      end else if (pick < 51) begin
        it.action = ACT_CLEAR;
      end else if (pick < 54) begin
        it.action = ACT_UNUSED;
      end else begin
        it.action = ACT_TICK;
        it.wday   = 3'($urandom_range(0, 6));
        if (sched_count != 0 && $urandom_range(0, 9) < 7) begin
          // aim the tick at a stored job so that matches are common
          j = sched_jobs[$urandom_range(0, sched_count - 1)];
          if (!j.minute_any) it.minute = j.minute;
          if (!j.hour_any)   it.hour   = j.hour;
          if (!j.mday_any)   it.mday   = j.mday;
          if (!j.month_any)  it.month  = j.month;
          if (!j.wday_any)   it.wday   = j.wday % 3'd7;
          // near miss now and then
          if ($urandom_range(0, 3) == 0) it.hour = 5'($urandom_range(0, 23));
        end else if ($urandom_range(0, 9) == 0) begin
          it.wday = 3'd7;
        end
      end
    end
    return it;
  endfunction

  task automatic add_row(ctm_in_t it, bit typed, ctm_out_t res);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  task automatic pace_input(ref int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  task automatic apply_item(ctm_in_t it, bit typed, ctm_out_t res);
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    do @(posedge clk); while (!in_chan.ready);
    step_schedule(it);
    if (typed) begin
      pending_results.push_back(res);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  task automatic report_mismatch(bit have_want, ctm_out_t want, ctm_out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      if (have_want)
        $display("%0t: result mismatch, expected %s, got %s", $time, fmt_res(want),
                 fmt_res(got));
      else
        $display("%0t: unexpected result %s", $time, fmt_res(got));
    end
  endtask

  // receiver: always ready, random stalls, or a slow fixed pattern
  always @(negedge clk) begin
    out_cyc <= out_cyc + 1;
    case ((out_cyc / 150) % 3)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
      default: out_chan.ready <= (out_cyc % 5 == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    ctm_out_t want;
    ctm_out_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.payload;
      if (pending_results.size() == 0) begin
        report_mismatch(1'b0, got, got);
      end else begin
        want = pending_results.pop_front();
        if (got.fired !== want.fired || got.fired_command !== want.fired_command ||
            got.job_index !== want.job_index || got.job_count !== want.job_count ||
            got.table_full !== want.table_full || got.last !== want.last)
          report_mismatch(1'b1, want, got);
      end
    end
  end

  initial begin : stimulus
    int burst_left;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.payload = '0;
    out_chan.ready  = 1'b0;
    burst_left      = 0;

    // tick on an empty table
    add_row(mk_item(ACT_TICK, 6'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 3'd0, 1'b0,
                    CMD_NONE), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd0, 1'b0, 1'b1));
    add_row(mk_item(ACT_ADD, 6'd0, 1'b1, 5'd0, 1'b1, 5'd1, 1'b1, 4'd1, 1'b1, 3'd0, 1'b1,
                    CMD_OPEN), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd1, 1'b0, 1'b1));
    // upper extremes, weekday 7 as sunday
    add_row(mk_item(ACT_ADD, 6'd59, 1'b0, 5'd23, 1'b0, 5'd31, 1'b0, 4'd12, 1'b0, 3'd7, 1'b0,
                    CMD_TEST), 1'b1, mk_res(1'b0, CMD_NONE, 4'd1, 5'd2, 1'b0, 1'b1));
    add_row(mk_item(ACT_ADD, 6'd0, 1'b0, 5'd0, 1'b0, 5'd1, 1'b0, 4'd1, 1'b0, 3'd0, 1'b0,
                    CMD_CLOSE), 1'b1, mk_res(1'b0, CMD_NONE, 4'd2, 5'd3, 1'b0, 1'b1));
    // unknown commands occupy a slot but never fire
    add_row(mk_item(ACT_ADD, 6'd0, 1'b1, 5'd0, 1'b1, 5'd1, 1'b1, 4'd1, 1'b1, 3'd0, 1'b1,
                    CMD_NONE), 1'b1, mk_res(1'b0, CMD_NONE, 4'd3, 5'd4, 1'b0, 1'b1));
    add_row(mk_item(ACT_ADD, 6'd0, 1'b1, 5'd0, 1'b1, 5'd1, 1'b1, 4'd1, 1'b1, 3'd0, 1'b1,
                    CMD_BAD), 1'b1, mk_res(1'b0, CMD_NONE, 4'd4, 5'd5, 1'b0, 1'b1));
    // out-of-range job values
    add_row(mk_item(ACT_ADD, 6'd63, 1'b0, 5'd31, 1'b0, 5'd0, 1'b0, 4'd15, 1'b0, 3'd6, 1'b0,
                    CMD_OFF), 1'b1, mk_res(1'b0, CMD_NONE, 4'd5, 5'd6, 1'b0, 1'b1));
    // wildcards with junk value bits beside them
    add_row(mk_item(ACT_ADD, 6'd63, 1'b1, 5'd31, 1'b1, 5'd31, 1'b1, 4'd15, 1'b1, 3'd0, 1'b0,
                    CMD_OFF), 1'b1, mk_res(1'b0, CMD_NONE, 4'd6, 5'd7, 1'b0, 1'b1));
    add_row(mk_item(ACT_TICK, 6'd59, 1'b0, 5'd23, 1'b0, 5'd31, 1'b0, 4'd12, 1'b0, 3'd0, 1'b0,
                    CMD_NONE), 1'b0, '0);
    add_row(mk_item(ACT_TICK, 6'd0, 1'b0, 5'd0, 1'b0, 5'd1, 1'b0, 4'd1, 1'b0, 3'd0, 1'b0,
                    CMD_NONE), 1'b0, '0);
    add_row(mk_item(ACT_TICK, 6'd59, 1'b0, 5'd23, 1'b0, 5'd31, 1'b0, 4'd12, 1'b0, 3'd7, 1'b0,
                    CMD_NONE), 1'b0, '0);
    add_row(mk_item(ACT_TICK, 6'd63, 1'b0, 5'd31, 1'b0, 5'd0, 1'b0, 4'd15, 1'b0, 3'd6, 1'b0,
                    CMD_NONE), 1'b0, '0);
    // fill the table up
    for (int k = 0; k < 9; k++) begin
      add_row(mk_item(ACT_ADD, 6'(k), 1'b1, 5'(k), 1'b1, 5'd1, 1'b1, 4'd1, 1'b1, 3'(k),
                      1'b1, CMD_CYCLE[k % 4]), 1'b1,
              mk_res(1'b0, CMD_NONE, 4'(7 + k), 5'(8 + k), 1'b0, 1'b1));
    end
    add_row(mk_item(ACT_ADD, 6'd30, 1'b0, 5'd12, 1'b0, 5'd15, 1'b0, 4'd6, 1'b0, 3'd3, 1'b0,
                    CMD_OPEN), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd16, 1'b1, 1'b1));
    add_row(mk_item(ACT_TICK, 6'd1, 1'b0, 5'd2, 1'b0, 5'd3, 1'b0, 4'd4, 1'b0, 3'd5, 1'b0,
                    CMD_NONE), 1'b0, '0);
    add_row(mk_item(ACT_CLEAR, 6'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 3'd0, 1'b0,
                    CMD_NONE), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd0, 1'b0, 1'b1));
    add_row(mk_item(ACT_TICK, 6'd59, 1'b0, 5'd23, 1'b0, 5'd31, 1'b0, 4'd12, 1'b0, 3'd0, 1'b0,
                    CMD_NONE), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd0, 1'b0, 1'b1));
    add_row(mk_item(ACT_UNUSED, 6'd63, 1'b1, 5'd31, 1'b1, 5'd31, 1'b1, 4'd15, 1'b1, 3'd7,
                    1'b1, CMD_BAD), 1'b1, mk_res(1'b0, CMD_NONE, 4'd0, 5'd0, 1'b0, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      pace_input(burst_left);
      apply_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
    end
    repeat (RAND_ITEMS) begin
      pace_input(burst_left);
      apply_item(rand_item(), 1'b0, '0);
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
